// ===== sv/tti_pkg.sv =====
package tti_pkg;

  // Command codes carried in the opcode field of an input item
  typedef enum logic [2:0] {
    OP_USEC    = 3'd0,
    OP_START   = 3'd1,
    OP_STOP    = 3'd2,
    OP_PAUSE   = 3'd3,
    OP_RESUME  = 3'd4,
    OP_SHIFT   = 3'd5,
    OP_ADD_OFS = 3'd6,
    OP_CLR_OFS = 3'd7
  } tti_op_e;

  localparam int unsigned CFG_W  = 17;
  localparam int unsigned VAL_W  = 18;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned SHFT_W = 17;
  localparam int unsigned OFS_W  = 10;
  localparam int unsigned TS_W   = 32;

  localparam logic [LEN_W-1:0] MIN_HALF_US     = 16'd100;
  localparam logic [LEN_W-1:0] MAX_HALF_US     = 16'd50000;
  localparam logic [LEN_W-1:0] DEFAULT_HALF_US = 16'd2500;
  localparam logic [CFG_W-1:0] DEFAULT_FULL_US = 17'd5000;
  localparam logic [OFS_W-1:0] OFFSET_LIMIT    = 10'd500;

endpackage

// ===== sv/tti_in_if.sv =====
interface tti_in_if import tti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic signed [VAL_W-1:0] value_us;

  modport source (output valid, output opcode, output value_us, input ready);
  modport sink   (input valid, input opcode, input value_us, output ready);
endinterface

// ===== sv/tti_out_if.sv =====
interface tti_out_if import tti_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    tick_fired;
  logic                    tock_fired;
  logic [TS_W-1:0]         timestamp_us;
  logic signed [OFS_W-1:0] offset_us;
  logic                    active;

  modport source (output valid, output tick_fired, output tock_fired, output timestamp_us,
                  output offset_us, output active, input ready);
  modport sink   (input valid, input tick_fired, input tock_fired, input timestamp_us,
                  input offset_us, input active, output ready);
endinterface

// ===== sv/tti_cfg_if.sv =====
interface tti_cfg_if import tti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] full_interval_us;

  modport source (output valid, output full_interval_us, input ready);
  modport sink   (input valid, input full_interval_us, output ready);
endinterface

// ===== sv/tick_tock_interval_timer_top.sv =====
// Tick/tock interval timer. Each input item is either one elapsed microsecond or a command
// (start, stop, pause, resume, phase shift, add/clear frequency offset); every item gives
// exactly one result carrying the tick and tock expiry flags, the timestamp, the current
// frequency offset and the active flag. The block takes one item per clock cycle, back to
// back; the result of an item passes the first stage and then the output register. The timer
// state is updated in the cycle of acceptance, and the timestamp multiply (half-tick count
// times half interval) sits in the stage after it, in front of the output register. The
// half interval is half of full_interval_us clamped to 100..50000 us; a write to it takes
// effect at once for timestamps and the next loads but does not reload the running count.
// The configuration port is always ready. Backpressure on the output stalls the two stages
// and holds off input only when both are full.
module tick_tock_interval_timer_top import tti_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  tti_in_if.sink    in_i,
  tti_out_if.source out_o,
  tti_cfg_if.sink   cfg_i
);

  localparam logic signed [18:0] LenMin = 19'(MIN_HALF_US);
  localparam logic signed [18:0] LenMax = 19'(MAX_HALF_US);
  localparam logic signed [18:0] OfsMax = 19'(OFFSET_LIMIT);
  localparam logic signed [18:0] OfsMin = -19'(OFFSET_LIMIT);

  // Clamp a signed length to the legal half-interval range
  function automatic logic [LEN_W-1:0] clamp_len(input logic signed [18:0] len);
    logic [LEN_W-1:0] res;
    if (len < LenMin) begin
      res = MIN_HALF_US;
    end else if (len > LenMax) begin
      res = MAX_HALF_US;
    end else begin
      res = len[LEN_W-1:0];
    end
    return res;
  endfunction

  // Configuration register
  logic [CFG_W-1:0] cfg_q;

  // Timer state
  logic [LEN_W-1:0]         rem_q, rem_d;
  logic [TS_W-1:0]          cnt_q, cnt_d;
  logic signed [SHFT_W-1:0] shift_q, shift_d;
  logic signed [OFS_W-1:0]  ofs_q, ofs_d;
  logic                     tock_next_q, tock_next_d;
  logic                     run_q, run_d;
  logic                     pause_q, pause_d;

  // First stage: updated state snapshot of one item
  logic                    s1_valid_q;
  logic [TS_W-1:0]         s1_cnt_q;
  logic [LEN_W-1:0]        s1_half_q;
  logic [LEN_W-1:0]        s1_elapsed_q;
  logic                    s1_tick_q;
  logic                    s1_tock_q;
  logic signed [OFS_W-1:0] s1_ofs_q;
  logic                    s1_active_q;

  // Output register
  logic                    out_valid_q;
  logic                    out_tick_q;
  logic                    out_tock_q;
  logic [TS_W-1:0]         out_ts_q;
  logic signed [OFS_W-1:0] out_ofs_q;
  logic                    out_active_q;

  logic             in_acc;
  logic             s1_adv;
  logic [LEN_W-1:0] half_raw;
  logic [LEN_W-1:0] half;
  logic [LEN_W-1:0] rem_dec;
  logic [LEN_W-1:0] tock_len;
  logic [LEN_W-1:0] tick_len;
  logic [LEN_W-1:0] elapsed;
  logic signed [18:0] val_x;
  logic signed [18:0] shift_hi;
  logic signed [18:0] shift_lo;
  logic signed [18:0] shift_clamped;
  logic signed [18:0] ofs_sum;
  logic signed [18:0] ofs_sat;
  logic             tick_f;
  logic             tock_f;
  logic [TS_W-1:0]  ts_d;
  tti_op_e          op;

  // Handshake: advance the first stage whenever the output slot frees up
  assign s1_adv      = !out_valid_q || out_o.ready;
  assign in_i.ready  = !s1_valid_q || s1_adv;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // Half interval from the configured full interval
  assign half_raw = cfg_q[CFG_W-1:1];
  always_comb begin
    if (half_raw < MIN_HALF_US) begin
      half = MIN_HALF_US;
    end else if (half_raw > MAX_HALF_US) begin
      half = MAX_HALF_US;
    end else begin
      half = half_raw;
    end
  end

  assign op       = tti_op_e'(in_i.opcode);
  assign val_x    = {in_i.value_us[VAL_W-1], in_i.value_us};
  assign rem_dec  = (rem_q != '0) ? rem_q - 16'd1 : '0;
  assign tock_len = clamp_len($signed({3'b000, half}) + {{2{shift_q[SHFT_W-1]}}, shift_q});
  assign tick_len = clamp_len($signed({3'b000, half}) + {{9{ofs_q[OFS_W-1]}}, ofs_q});
  assign shift_hi = LenMax - $signed({3'b000, half});
  assign shift_lo = LenMin - $signed({3'b000, half});
  assign ofs_sum  = {{9{ofs_q[OFS_W-1]}}, ofs_q} + val_x;

  always_comb begin
    if (val_x > shift_hi) begin
      shift_clamped = shift_hi;
    end else if (val_x < shift_lo) begin
      shift_clamped = shift_lo;
    end else begin
      shift_clamped = val_x;
    end
    if (ofs_sum > OfsMax) begin
      ofs_sat = OfsMax;
    end else if (ofs_sum < OfsMin) begin
      ofs_sat = OfsMin;
    end else begin
      ofs_sat = ofs_sum;
    end
  end

  // Next timer state for the item at the input
  always_comb begin
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    ofs_d       = ofs_q;
    tock_next_d = tock_next_q;
    run_d       = run_q;
    pause_d     = pause_q;
    tick_f      = 1'b0;
    tock_f      = 1'b0;
    unique case (op)
      OP_USEC: begin
        if (run_q && !pause_q) begin
          if (rem_dec == '0) begin
            // Expiry: count the half-tick and load the next length
            cnt_d = cnt_q + 32'd1;
            if (tock_next_q) begin
              tock_f      = 1'b1;
              tock_next_d = 1'b0;
              rem_d       = tock_len;
              shift_d     = '0;
            end else begin
              tick_f      = 1'b1;
              tock_next_d = 1'b1;
              rem_d       = tick_len;
            end
          end else begin
            rem_d = rem_dec;
          end
        end
      end
      OP_START: begin
        if (!run_q) begin
          run_d       = 1'b1;
          pause_d     = 1'b0;
          tock_next_d = 1'b1;
        end
      end
      OP_STOP: begin
        run_d = 1'b0;
      end
      OP_PAUSE: begin
        if (run_q && !pause_q) begin
          pause_d = 1'b1;
        end
      end
      OP_RESUME: begin
        if (run_q && pause_q) begin
          tock_next_d = 1'b1;
          rem_d       = half;
          pause_d     = 1'b0;
        end
      end
      OP_SHIFT: begin
        shift_d = shift_clamped[SHFT_W-1:0];
      end
      OP_ADD_OFS: begin
        ofs_d = ofs_sat[OFS_W-1:0];
      end
      OP_CLR_OFS: begin
        ofs_d = '0;
      end
    endcase
  end

  // Time gone by in the current half-interval, after this item's update
  assign elapsed = (rem_d <= half) ? half - rem_d : '0;

  // Timestamp: half-ticks times half interval plus elapsed, wrapping at 32 bits
  assign ts_d = s1_cnt_q * {16'd0, s1_half_q} + {16'd0, s1_elapsed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= DEFAULT_FULL_US;
      rem_q       <= DEFAULT_HALF_US;
      cnt_q       <= '0;
      shift_q     <= '0;
      ofs_q       <= '0;
      tock_next_q <= 1'b1;
      run_q       <= 1'b0;
      pause_q     <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.full_interval_us;
      end
      if (in_acc) begin
        rem_q       <= rem_d;
        cnt_q       <= cnt_d;
        shift_q     <= shift_d;
        ofs_q       <= ofs_d;
        tock_next_q <= tock_next_d;
        run_q       <= run_d;
        pause_q     <= pause_d;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers: hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cnt_q     <= cnt_d;
      s1_half_q    <= half;
      s1_elapsed_q <= elapsed;
      s1_tick_q    <= tick_f;
      s1_tock_q    <= tock_f;
      s1_ofs_q     <= ofs_d;
      s1_active_q  <= run_d && !pause_d;
    end
    if (s1_valid_q && s1_adv) begin
      out_tick_q   <= s1_tick_q;
      out_tock_q   <= s1_tock_q;
      out_ts_q     <= ts_d;
      out_ofs_q    <= s1_ofs_q;
      out_active_q <= s1_active_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.tick_fired   = out_tick_q;
  assign out_o.tock_fired   = out_tock_q;
  assign out_o.timestamp_us = out_ts_q;
  assign out_o.offset_us    = out_ofs_q;
  assign out_o.active       = out_active_q;

  // The remaining count never rises above the maximum half interval
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= MAX_HALF_US)
    else $error("remaining count above maximum half interval");

  // An item never fires both tick and tock
  a_one_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_tick_q && s1_tock_q))
    else $error("tick and tock fired on one item");

  // An accepted item occupies the first stage in the next cycle
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted item lost before first stage");

  // Frequency offset stays saturated
  a_ofs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ofs_q <= $signed(OFFSET_LIMIT)) && (ofs_q >= -$signed(OFFSET_LIMIT)))
    else $error("frequency offset outside saturation limits");

  // A stalled first stage keeps its item
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_cnt_q)))
    else $error("first stage item dropped under backpressure");

endmodule
